// ===== rtl/core/kedec_pkg.sv =====
// ----------------------------------------------------------------------------
// kedec_pkg
// Shared types, constants and key-position functions for the keypad event
// decoder.
// ----------------------------------------------------------------------------
package kedec_pkg;

    // Default scan size of the raw matrix
    localparam int RawRowsDef = 7;
    localparam int RawColsDef = 8;

    // Logical layout: 4 rows by 14 columns
    localparam int LogCols  = 14;
    localparam int KeyCount = 56;

    // Depth of the decoupling queues
    localparam int QueueDepth = 2;

    // Modifier bit positions in the held-modifier mask
    localparam int ModShift = 0;
    localparam int ModCtrl  = 1;
    localparam int ModAlt   = 2;
    localparam int ModOpt   = 3;

    // Navigation codes
    typedef enum logic [2:0] {
        NAV_NONE  = 3'd0,
        NAV_UP    = 3'd1,
        NAV_DOWN  = 3'd2,
        NAV_LEFT  = 3'd3,
        NAV_RIGHT = 3'd4,
        NAV_ENTER = 3'd5
    } t_nav;

    // Classified event passed from front to back
    typedef struct packed {
        logic       press;
        logic [1:0] lrow;
        logic [3:0] lcol;
        logic [5:0] idx;
    } t_item;

    // One result delivered on the output side
    typedef struct packed {
        logic       press;
        logic [1:0] lrow;
        logic [3:0] lcol;
        logic [5:0] idx;
        logic       is_mod;
        logic       is_let;
        logic       shift_sel;
        logic [3:0] mods;
        logic       caps;
        t_nav       nav;
    } t_result;

    // Modifier mask bit that a logical position drives (zero if none)
    function automatic logic [3:0] mod_bits(input logic [1:0] r, input logic [3:0] c);
        logic [3:0] m;
        m = 4'b0000;
        if (r == 2'd2 && c == 4'd0) m[ModShift] = 1'b1;
        if (r == 2'd3 && c == 4'd0) m[ModCtrl]  = 1'b1;
        if (r == 2'd3 && c == 4'd2) m[ModAlt]   = 1'b1;
        if (r == 2'd3 && c == 4'd1) m[ModOpt]   = 1'b1;
        return m;
    endfunction

    // Caps lock position
    function automatic logic is_caps(input logic [1:0] r, input logic [3:0] c);
        return (r == 2'd2) && (c == 4'd1);
    endfunction

    // Letter keys a to z
    function automatic logic letter_at(input logic [1:0] r, input logic [3:0] c);
        logic l;
        case (r)
            2'd1: begin
                l = (c >= 4'd1) && (c <= 4'd10);
            end
            2'd2: begin
                l = (c >= 4'd2) && (c <= 4'd10);
            end
            2'd3: begin
                l = (c >= 4'd3) && (c <= 4'd9);
            end
            default: begin
                l = 1'b0;
            end
        endcase
        return l;
    endfunction

    // Navigation code of a position
    function automatic t_nav nav_at(input logic [1:0] r, input logic [3:0] c);
        t_nav n;
        n = NAV_NONE;
        if (r == 2'd2 && c == 4'd11) n = NAV_UP;
        if (r == 2'd3 && c == 4'd11) n = NAV_DOWN;
        if (r == 2'd3 && c == 4'd10) n = NAV_LEFT;
        if (r == 2'd3 && c == 4'd12) n = NAV_RIGHT;
        if (r == 2'd2 && c == 4'd13) n = NAV_ENTER;
        return n;
    endfunction

endpackage

// ===== rtl/core/kedec_fifo.sv =====
// ----------------------------------------------------------------------------
// kedec_fifo
// Small first-word fall-through queue between decoder stages.
// ----------------------------------------------------------------------------
module kedec_fifo
    import kedec_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    // Hold pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/kedec_front.sv =====
// ----------------------------------------------------------------------------
// kedec_front
// Splits the raw event byte into matrix row and column, drops empty and
// out-of-scan events, and maps the key onto the logical layout.
// ----------------------------------------------------------------------------
module kedec_front
    import kedec_pkg::*;
#(
    parameter int RAW_ROWS = RawRowsDef,
    parameter int RAW_COLS = RawColsDef
) (
    input  logic       i_push,
    input  logic [7:0] i_event_byte,
    input  logic       i_full,
    output logic       o_wr,
    output t_item      o_item
);

    logic [6:0]  code;
    logic [6:0]  raw;
    logic [14:0] prod;
    logic [3:0]  rrow;
    logic [6:0]  rrow_x10;
    logic [3:0]  rcol;
    logic        in_scan;
    logic [1:0]  lrow;
    logic [3:0]  lcol;

    // Divide by ten through reciprocal multiply (exact for 7-bit values)
    always_comb begin
        code     = i_event_byte[6:0];
        raw      = code - 7'd1;
        prod     = 15'(raw) * 15'd205;
        rrow     = prod[14:11];
        rrow_x10 = 7'({3'b000, rrow} * 7'd10);
        rcol     = 4'(raw - rrow_x10);
    end

    // Classify and remap to the logical layout
    always_comb begin
        in_scan = (code != 7'd0) && (rrow < 4'(RAW_ROWS)) && (rcol < 4'(RAW_COLS));
        lrow    = rcol[1:0];
        lcol    = {rrow[2:0], (rcol > 4'd3)};
        o_item.press = i_event_byte[7];
        o_item.lrow  = lrow;
        o_item.lcol  = lcol;
        o_item.idx   = 6'({lrow, 4'b0000}) - 6'({lrow, 1'b0}) + 6'(lcol);
        o_wr         = i_push && !i_full && in_scan;
    end

endmodule

// ===== rtl/core/kedec_back.sv =====
// ----------------------------------------------------------------------------
// kedec_back
// Filters repeated presses and releases against the pressed-key mask,
// tracks modifiers and caps lock, and builds one result per non-repeated event.
// ----------------------------------------------------------------------------
module kedec_back
    import kedec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_empty,
    input  logic    i_full,
    output logic    o_rd,
    output logic    o_wr,
    output t_result o_result
);

    logic [KeyCount-1:0] r_pressed, n_pressed;
    logic [3:0]          r_mods, n_mods;
    logic                r_caps, n_caps;
    logic                hit;
    logic                take;
    logic [3:0]          mbit;
    logic                caps_key;
    logic                is_mod;
    logic                is_let;

    // Look up key state and position class
    always_comb begin
        o_rd     = !i_empty && !i_full;
        hit      = r_pressed[i_item.idx];
        take     = o_rd && (hit != i_item.press);
        mbit     = mod_bits(i_item.lrow, i_item.lcol);
        caps_key = is_caps(i_item.lrow, i_item.lcol);
        is_mod   = (mbit != 4'b0000) || caps_key;
        is_let   = letter_at(i_item.lrow, i_item.lcol);
    end

    // Update pressed mask, modifiers and caps lock
    always_comb begin
        n_pressed = r_pressed;
        n_mods    = r_mods;
        n_caps    = r_caps;
        if (take) begin
            n_pressed[i_item.idx] = i_item.press;
            if (mbit != 4'b0000) begin
                n_mods = i_item.press ? (r_mods | mbit) : (r_mods & ~mbit);
            end else if (caps_key && i_item.press) begin
                n_caps = ~r_caps;
            end
        end
    end

    // Build the result from the state after this event
    always_comb begin
        o_wr                 = take;
        o_result.press       = i_item.press;
        o_result.lrow        = i_item.lrow;
        o_result.lcol        = i_item.lcol;
        o_result.idx         = i_item.idx;
        o_result.is_mod      = is_mod;
        o_result.is_let      = is_let;
        o_result.mods        = n_mods;
        o_result.caps        = n_caps;
        o_result.nav         = i_item.press ? nav_at(i_item.lrow, i_item.lcol) : NAV_NONE;
        if (is_mod) begin
            o_result.shift_sel = 1'b0;
        end else if (is_let) begin
            o_result.shift_sel = n_mods[ModShift] ^ n_caps;
        end else begin
            o_result.shift_sel = n_mods[ModShift];
        end
    end

    // Hold key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= '0;
            r_mods    <= '0;
            r_caps    <= 1'b0;
        end else begin
            r_pressed <= n_pressed;
            r_mods    <= n_mods;
            r_caps    <= n_caps;
        end
    end

endmodule

// ===== rtl/core/keypad_event_decoder_core.sv =====
// ----------------------------------------------------------------------------
// keypad_event_decoder_core
// Keypad event decoder: raw key event bytes in, logical key results out.
// ----------------------------------------------------------------------------
// The block takes one raw key event byte per cycle while full is low (bit 7
// press, bits 6..0 key code) and returns at most one result per event: the
// logical position on a 4x14 layout, key class, modifier and caps lock
// state, shifted choice and navigation code. Empty codes, positions outside
// the scan and repeated presses or releases produce no result. An accepted
// event is registered in the middle queue and its result in the output
// queue before it can be popped; the back stage updates the pressed mask
// and modifiers for one event per clock while the output queue is not
// full. Both sides behave as queues, so either side may stall without
// losing data.
// ----------------------------------------------------------------------------
module keypad_event_decoder_core
    import kedec_pkg::*;
#(
    parameter int RAW_ROWS = RawRowsDef,
    parameter int RAW_COLS = RawColsDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_event_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_pressed,
    output logic [1:0] o_logical_row,
    output logic [3:0] o_logical_col,
    output logic [5:0] o_key_index,
    output logic       o_mod_key,
    output logic       o_alpha_key,
    output logic       o_shift_sel,
    output logic [3:0] o_modifier_mask,
    output logic       o_caps_lock,
    output logic [2:0] o_nav_key
);

    localparam int ItemW = $bits(t_item);
    localparam int ResW  = $bits(t_result);

    logic       fr_wr;
    t_item      fr_item;
    logic       mid_full, mid_empty;
    t_item      mid_item;
    logic       bk_rd, bk_wr;
    t_result    bk_result;
    logic       out_full;
    t_result    out_result;

    // Classify incoming events
    kedec_front #(
        .RAW_ROWS (RAW_ROWS),
        .RAW_COLS (RAW_COLS)
    ) u_front (
        .i_push       (push),
        .i_event_byte (i_event_byte),
        .i_full       (mid_full),
        .o_wr         (fr_wr),
        .o_item       (fr_item)
    );

    assign full = mid_full;

    // Decouple front from back
    kedec_fifo #(
        .WIDTH (ItemW),
        .DEPTH (QueueDepth)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_wr),
        .i_data  (fr_item),
        .i_rd    (bk_rd),
        .o_data  (mid_item),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    // Filter repeats and track key state
    kedec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (mid_item),
        .i_empty  (mid_empty),
        .i_full   (out_full),
        .o_rd     (bk_rd),
        .o_wr     (bk_wr),
        .o_result (bk_result)
    );

    // Hold results until taken
    kedec_fifo #(
        .WIDTH (ResW),
        .DEPTH (QueueDepth)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (bk_wr),
        .i_data  (bk_result),
        .i_rd    (pop),
        .o_data  (out_result),
        .o_full  (out_full),
        .o_empty (empty)
    );

    // Drive result ports
    assign o_pressed       = out_result.press;
    assign o_logical_row   = out_result.lrow;
    assign o_logical_col   = out_result.lcol;
    assign o_key_index     = out_result.idx;
    assign o_mod_key       = out_result.is_mod;
    assign o_alpha_key     = out_result.is_let;
    assign o_shift_sel     = out_result.shift_sel;
    assign o_modifier_mask = out_result.mods;
    assign o_caps_lock     = out_result.caps;
    assign o_nav_key       = out_result.nav;

endmodule

// ===== rtl/core/kedec_checker.sv =====
// ----------------------------------------------------------------------------
// kedec_checker
// Port-level checks on the keypad event decoder, bound to the top level.
// ----------------------------------------------------------------------------
module kedec_checker
    import kedec_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_pressed,
    input logic [1:0] o_logical_row,
    input logic [3:0] o_logical_col,
    input logic [5:0] o_key_index,
    input logic       o_mod_key,
    input logic       o_alpha_key,
    input logic       o_shift_sel,
    input logic [2:0] o_nav_key
);

    // Come out of reset with the output queue empty and the input queue not full
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not drained after reset");

    // Hold a waiting result until the transaction completes
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_key_index) && $stable(o_pressed)))
        else $error("waiting result changed before pop");

    // Key index follows the logical position
    a_index_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_key_index ==
            6'({o_logical_row, 4'b0000}) - 6'({o_logical_row, 1'b0}) + 6'(o_logical_col)))
        else $error("key index does not match logical position");

    // Modifiers never pick a shifted symbol, a letter or a navigation code
    a_modifier_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mod_key) |->
            (!o_shift_sel && !o_alpha_key && o_nav_key == NAV_NONE))
        else $error("modifier result carries key attributes");

    // Releases carry no navigation code
    a_nav_press_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_pressed) |-> (o_nav_key == NAV_NONE))
        else $error("navigation code on a release");

endmodule

bind keypad_event_decoder_core kedec_checker u_kedec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_pressed     (o_pressed),
    .o_logical_row (o_logical_row),
    .o_logical_col (o_logical_col),
    .o_key_index   (o_key_index),
    .o_mod_key     (o_mod_key),
    .o_alpha_key   (o_alpha_key),
    .o_shift_sel   (o_shift_sel),
    .o_nav_key     (o_nav_key)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keypad_event_decoder_core. Raw key event bytes go
// in through the push/full side; decoded key results come back through the
// empty/pop side. Each result is checked field by field against a local
// decoder with its own pressed-key mask, held modifiers and caps lock state.
// ----------------------------------------------------------------------------
module tb;
    import kedec_pkg::*;

    localparam int ScanRows   = RawRowsDef;
    localparam int ScanCols   = RawColsDef;
    localparam int QuietLimit = 1000;
    localparam int DrainTail  = 20;
    localparam int PhaseItems = 330;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_event_byte;
    logic       empty;
    logic       pop;
    logic       o_pressed;
    logic [1:0] o_logical_row;
    logic [3:0] o_logical_col;
    logic [5:0] o_key_index;
    logic       o_mod_key;
    logic       o_alpha_key;
    logic       o_shift_sel;
    logic [3:0] o_modifier_mask;
    logic       o_caps_lock;
    logic [2:0] o_nav_key;

    // Decoder state as seen by the bench
    logic [KeyCount-1:0] keys_down = '0;
    logic [3:0]          mods_held = '0;
    logic                caps_on   = 1'b0;

    t_result pending_results[$];
    t_result want;
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      hold_request  = 0;
    int      hold_left     = 0;

    // Modifier, caps lock and navigation positions, favored by random traffic
    logic [1:0] spec_row [10] = '{2'd2, 2'd2, 2'd3, 2'd3, 2'd3,
                                  2'd2, 2'd3, 2'd3, 2'd3, 2'd2};
    logic [3:0] spec_col [10] = '{4'd0, 4'd1, 4'd0, 4'd1, 4'd2,
                                  4'd11, 4'd11, 4'd10, 4'd12, 4'd13};

    keypad_event_decoder_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_event_byte   (i_event_byte),
        .empty          (empty),
        .pop            (pop),
        .o_pressed      (o_pressed),
        .o_logical_row  (o_logical_row),
        .o_logical_col  (o_logical_col),
        .o_key_index    (o_key_index),
        .o_mod_key      (o_mod_key),
        .o_alpha_key    (o_alpha_key),
        .o_shift_sel    (o_shift_sel),
        .o_modifier_mask(o_modifier_mask),
        .o_caps_lock    (o_caps_lock),
        .o_nav_key      (o_nav_key)
    );

    // Generate the 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Raw key code of a logical position
    function automatic logic [6:0] pos_code(input logic [1:0] lr, input logic [3:0] lc);
        return 7'((int'(lc) / 2) * 10 + int'(lr) + 4 * (int'(lc) % 2) + 1);
    endfunction

    // Decode one event, advance the key state, return 1 when a result is due
    function automatic bit decode_key_event(input logic [7:0] ev, output t_result res);
        int         raw_row;
        int         raw_col;
        logic       prs;
        logic [1:0] lr;
        logic [3:0] lc;
        logic [5:0] ix;
        logic [3:0] mbit;
        logic       caps_key;
        logic       letter;
        res = '0;
        prs = ev[7];
        if (ev[6:0] == 7'd0) return 1'b0;
        raw_row = (int'(ev[6:0]) - 1) / 10;
        raw_col = (int'(ev[6:0]) - 1) % 10;
        if (raw_row >= ScanRows || raw_col >= ScanCols) return 1'b0;
        lr = 2'(raw_col % 4);
        lc = 4'(raw_row * 2 + ((raw_col > 3) ? 1 : 0));
        ix = 6'(int'(lr) * LogCols + int'(lc));

        // Drop repeated presses and releases
        if (keys_down[ix] == prs) return 1'b0;
        keys_down[ix] = prs;

        mbit = 4'b0000;
        if (lr == 2'd2 && lc == 4'd0) mbit[ModShift] = 1'b1;
        if (lr == 2'd3 && lc == 4'd0) mbit[ModCtrl]  = 1'b1;
        if (lr == 2'd3 && lc == 4'd2) mbit[ModAlt]   = 1'b1;
        if (lr == 2'd3 && lc == 4'd1) mbit[ModOpt]   = 1'b1;
        caps_key = (lr == 2'd2) && (lc == 4'd1);

        // Track held modifiers; toggle caps lock on press only
        if (mbit != 4'b0000) begin
            mods_held = prs ? (mods_held | mbit) : (mods_held & ~mbit);
        end else if (caps_key && prs) begin
            caps_on = ~caps_on;
        end

        case (lr)
            2'd1: letter = (lc >= 4'd1) && (lc <= 4'd10);
            2'd2: letter = (lc >= 4'd2) && (lc <= 4'd10);
            2'd3: letter = (lc >= 4'd3) && (lc <= 4'd9);
            default: letter = 1'b0;
        endcase

        res.press  = prs;
        res.lrow   = lr;
        res.lcol   = lc;
        res.idx    = ix;
        res.is_mod = (mbit != 4'b0000) || caps_key;
        res.is_let = letter;
        if (res.is_mod) begin
            res.shift_sel = 1'b0;
        end else if (letter) begin
            res.shift_sel = mods_held[ModShift] ^ caps_on;
        end else begin
            res.shift_sel = mods_held[ModShift];
        end
        res.mods = mods_held;
        res.caps = caps_on;
        res.nav  = NAV_NONE;
        if (prs) begin
            if (lr == 2'd2 && lc == 4'd11) res.nav = NAV_UP;
            if (lr == 2'd3 && lc == 4'd11) res.nav = NAV_DOWN;
            if (lr == 2'd3 && lc == 4'd10) res.nav = NAV_LEFT;
            if (lr == 2'd3 && lc == 4'd12) res.nav = NAV_RIGHT;
            if (lr == 2'd2 && lc == 4'd13) res.nav = NAV_ENTER;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Offer one event, hold it until accepted, then record its expected result
    task automatic send_event(input logic [7:0] ev);
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_event_byte <= ev;
        do @(posedge i_clk); while (full);
        if (decode_key_event(ev, res)) pending_results.push_back(res);
    endtask

    // Drop push and wait until every expected result has come back
    task automatic drain;
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick a mostly well-formed event: toggle a key, repeat its state, or noise
    task automatic send_random_event;
        int         r;
        int         k;
        logic [1:0] lr;
        logic [3:0] lc;
        logic       prs;
        r = $urandom_range(99);
        if (r < 20) begin
            send_event(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(3) == 0) begin
                k  = $urandom_range(9);
                lr = spec_row[k];
                lc = spec_col[k];
            end else begin
                k  = $urandom_range(KeyCount - 1);
                lr = 2'(k / LogCols);
                lc = 4'(k % LogCols);
            end
            prs = keys_down[int'(lr) * LogCols + int'(lc)];
            if (r < 90) prs = ~prs;
            send_event({prs, pos_code(lr, lc)});
        end
    endtask

    // Extremes, dropped events and the modifier, caps and navigation keys
    task automatic test_directed;
        send_idle_pct = 0;
        stall_pct     = 0;
        send_event(8'h00);                        // code zero, release
        send_event(8'h80);                        // code zero, press
        send_event(8'hFF);                        // far outside the scan
        send_event(8'h89);                        // raw column past the scan
        send_event(8'hC7);                        // raw row past the scan
        send_event(8'h81);                        // first key, press
        send_event(8'h81);                        // repeated press
        send_event(8'h01);                        // release
        send_event(8'h01);                        // repeated release
        send_event(8'hC4);                        // last key, press
        send_event({1'b1, pos_code(2'd2, 4'd0)}); // shift
        send_event({1'b1, pos_code(2'd1, 4'd1)}); // letter with shift
        send_event({1'b1, pos_code(2'd2, 4'd1)}); // caps on
        send_event({1'b0, pos_code(2'd2, 4'd1)}); // caps release, no change
        send_event({1'b0, pos_code(2'd1, 4'd1)}); // letter, shift xor caps
        send_event({1'b0, pos_code(2'd2, 4'd0)}); // shift release
        send_event({1'b1, pos_code(2'd3, 4'd0)}); // ctrl
        send_event({1'b1, pos_code(2'd3, 4'd2)}); // alt
        send_event({1'b1, pos_code(2'd3, 4'd1)}); // opt
        send_event({1'b1, pos_code(2'd2, 4'd11)}); // up
        send_event({1'b1, pos_code(2'd3, 4'd11)}); // down
        send_event({1'b1, pos_code(2'd3, 4'd10)}); // left
        send_event({1'b1, pos_code(2'd3, 4'd12)}); // right
        send_event({1'b1, pos_code(2'd2, 4'd13)}); // enter
        send_event({1'b0, pos_code(2'd2, 4'd13)}); // enter release, no nav
        drain();
    endtask

    // Hold off the receiver so the block fills and stalls its input
    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 200;
        repeat (30) send_random_event();
        drain();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (PhaseItems) send_random_event();
        drain();
    endtask

    // Drive pop; honor a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual key_index %0d",
                         $time, o_key_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("pressed",       want.press,     o_pressed);
                check_field("logical_row",   want.lrow,      o_logical_row);
                check_field("logical_col",   want.lcol,      o_logical_col);
                check_field("key_index",     want.idx,       o_key_index);
                check_field("mod_key",       want.is_mod,    o_mod_key);
                check_field("alpha_key",     want.is_let,    o_alpha_key);
                check_field("shift_sel",     want.shift_sel, o_shift_sel);
                check_field("modifier_mask", want.mods,      o_modifier_mask);
                check_field("caps_lock",     want.caps,      o_caps_lock);
                check_field("nav_key",       want.nav,       o_nav_key);
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QuietLimit) begin
                $display("%0t: timeout with %0d results outstanding",
                         $time, pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_event_byte = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(58, 0);
        test_random_phase(0, 58);
        test_random_phase(29, 29);

        // Let any stray result surface before the verdict
        repeat (DrainTail) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/kedec_pkg.sv
rtl/core/kedec_fifo.sv
rtl/core/kedec_front.sv
rtl/core/kedec_back.sv
rtl/core/keypad_event_decoder_core.sv
rtl/core/kedec_checker.sv
sim/tb.sv
